// ===== src/skt_pkg.sv =====
`default_nettype none
package skt_pkg;
  localparam int unsigned CapacityDef = 256;
  localparam int unsigned KeyW = 32;
  localparam int unsigned TagW = 4;
  localparam int unsigned ValW = 64;
  localparam int unsigned EntryW = KeyW + TagW + ValW;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpLookup = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;
  localparam logic [1:0] OpNone   = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StDup     = 2'd1;
  localparam logic [1:0] StMissing = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;
endpackage
`default_nettype wire

// ===== src/skt_ram.sv =====
`default_nettype none
module skt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/sorted_key_table_engine_top.sv =====
// Sorted key table: one operation at a time, one result word per input word.
// Each search probe reads a RAM entry, then compares it; there are at most
// log2(CAPACITY)+1 probes. Insert and remove then move entries one at a time
// (read, then write), and insert also writes the new entry. A new word is
// accepted only after the previous result has been taken. Reset (rst_ni low,
// asynchronous) empties the table; the RAM keeps no reset.
`default_nettype none
module sorted_key_table_engine_top
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        op_i,
  input  wire logic signed [31:0] key_i,
  input  wire logic [3:0]        type_tag_i,
  input  wire logic [63:0]       payload_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             status_o,
  output logic [3:0]             found_tag_o,
  output logic [63:0]            found_value_o,
  output logic [8:0]             occupancy_o
);
  // Address width and a count width that can hold CAPACITY itself.
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_CMP, S_SHIFT_RD, S_SHIFT_WR, S_PUT, S_DONE
  } state_e;

  state_e        state_q;
  logic [1:0]    op_q;
  logic [KeyW-1:0] bkey_q;   // key with sign bit flipped: unsigned order
  logic [TagW-1:0] tag_q;
  logic [ValW-1:0] val_q;
  logic [CW-1:0] lo_q, hi_q, cnt_q, idx_q;
  logic [CW-1:0] mid;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [KeyW-1:0] rkey;

  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [TagW-1:0] ftag_q;
  logic [ValW-1:0] fval_q;

  assign mid  = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign rkey = rdata[EntryW-1 -: KeyW];

  skt_ram #(.Width(EntryW), .Depth(CAPACITY)) u_entries (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Memory access control. During an insert shift idx walks down from the top,
  // during a remove shift it walks up from the hit slot.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rdata;
    raddr = mid[AW-1:0];
    unique case (state_q)
      S_SHIFT_RD: begin
        raddr = (op_q == OpInsert) ? AW'(idx_q - 1'b1) : AW'(idx_q + 1'b1);
      end
      S_SHIFT_WR: begin
        we = 1'b1;
      end
      S_PUT: begin
        we    = 1'b1;
        wdata = {bkey_q, tag_q, val_q};
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      idx_q       <= '0;
      op_q        <= OpNone;
      bkey_q      <= '0;
      tag_q       <= '0;
      val_q       <= '0;
      status_q    <= StOk;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            op_q   <= op_i;
            bkey_q <= {~key_i[31], key_i[30:0]};
            tag_q  <= type_tag_i;
            val_q  <= payload_i;
            lo_q   <= '0;
            hi_q   <= cnt_q;
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          // An empty range ends the search without a hit at lo.
          if (op_q == OpNone) begin
            status_q <= StOk;
            state_q  <= S_DONE;
          end else if (lo_q >= hi_q) begin
            if (op_q != OpInsert) begin
              status_q <= StMissing;
              state_q  <= S_DONE;
            end else if (cnt_q >= CapC) begin
              status_q <= StFull;
              state_q  <= S_DONE;
            end else begin
              status_q <= StOk;
              idx_q    <= cnt_q;
              state_q  <= (cnt_q == lo_q) ? S_PUT : S_SHIFT_RD;
            end
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (bkey_q > rkey) begin
            lo_q    <= mid + 1'b1;
            state_q <= S_PROBE;
          end else if (bkey_q < rkey) begin
            hi_q    <= mid;
            state_q <= S_PROBE;
          end else begin
            lo_q <= mid;
            unique case (op_q)
              OpInsert: begin
                status_q <= StDup;
                state_q  <= S_DONE;
              end
              OpLookup: begin
                status_q <= StOk;
                state_q  <= S_DONE;
              end
              default: begin
                status_q <= StOk;
                idx_q    <= mid;
                if (mid + 1'b1 >= cnt_q) begin
                  cnt_q   <= cnt_q - 1'b1;
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_SHIFT_RD;
                end
              end
            endcase
          end
        end
        S_SHIFT_RD: begin
          state_q <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (op_q == OpInsert) begin
            idx_q   <= idx_q - 1'b1;
            state_q <= (idx_q - 1'b1 == lo_q) ? S_PUT : S_SHIFT_RD;
          end else begin
            idx_q <= idx_q + 1'b1;
            if (idx_q + 2'd2 >= cnt_q) begin
              cnt_q   <= cnt_q - 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SHIFT_RD;
            end
          end
        end
        S_PUT: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Lookup data is captured from the RAM word at the hit cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_PROBE) begin
      ftag_q <= '0;
      fval_q <= '0;
    end else if (state_q == S_CMP && op_q == OpLookup && bkey_q == rkey) begin
      ftag_q <= rdata[ValW +: TagW];
      fval_q <= rdata[ValW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_tag_o   = ftag_q;
  assign found_value_o = fval_q;
  assign occupancy_o   = 9'(cnt_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapC) else $error("entry count above capacity");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("accept while busy");
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> idx_q < CapC) else $error("write beyond capacity");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> out_valid_q) else $error("result lost");
`endif
endmodule
`default_nettype wire
